FILE: rtl/core/url_query_field_extractor_macros.svh
// ----------------------------------------------------------------------------
// URL query field extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef URL_QUERY_FIELD_EXTRACTOR_MACROS_SVH
`define URL_QUERY_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication.
`define UQFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UQFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/uqfe_pkg.sv
// ----------------------------------------------------------------------------
// uqfe_pkg
// Types and constants shared by the URL query field extractor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uqfe_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2
  } uqfe_phase_t;

  localparam int NUM_NAMES = 4;
  localparam int MAX_TAKES = 3;
  localparam int MAX_RES   = 4;
  localparam int NAME_MAX  = 17;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] KPOS_MAX = 5'd31;

  // Names are right-justified: first character sits in the highest used byte.
  localparam logic [NAME_MAX*8-1:0] NAME_TXT [NUM_NAMES] = '{
    "code", "state", "error", {"error", "_description"}
  };
  localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{5'd4, 5'd5, 5'd5, 5'd17};

  typedef logic [1:0] uqfe_field_t;

  // One accepted URL byte, classified: decoded bytes plus parser events.
  typedef struct packed {
    logic                          key_ctx;
    logic [1:0]                    n_take;
    logic [MAX_TAKES-1:0][7:0]     take_byte;
    logic                          upd_raw;
    logic                          raw_clear;
    logic                          ev_key_end;
    logic                          ev_to_value;
    logic                          ev_val_end;
    logic                          ev_start;
    logic                          ev_reset;
  } uqfe_pkt_t;

  typedef struct packed {
    uqfe_field_t field;
    logic        has_byte;
    logic [7:0]  data;
    logic        value_end;
    logic        run_last;
  } uqfe_res_t;

endpackage

FILE: rtl/core/uqfe_intf.sv
// ----------------------------------------------------------------------------
// uqfe channel interfaces
// Valid/ready channels for URL bytes in and extracted field bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uqfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       url_last;

  modport source (output valid, output url_byte, output url_last, input ready);
  modport sink   (input valid, input url_byte, input url_last, output ready);
endinterface

interface uqfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] field;
  logic       has_byte;
  logic [7:0] data;
  logic       value_end;
  logic       run_last;

  modport source (output valid, output field, output has_byte, output data,
                  output value_end, output run_last, input ready);
  modport sink   (input valid, input field, input has_byte, input data,
                  input value_end, input run_last, output ready);
endinterface

FILE: rtl/core/url_query_field_extractor.sv
// ----------------------------------------------------------------------------
// url_query_field_extractor
// URL bytes are queued as packets; results leave through an output register.
// Throughput: one URL byte per cycle while the queue has room, one result per
// cycle while out_ch.ready; a byte with k results (up to 4) holds the parser.
// Reset: synchronous rst_n clears phase, decoder, match state and queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "url_query_field_extractor_macros.svh"

module url_query_field_extractor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  uqfe_in_if.sink    in_ch,
  uqfe_out_if.source out_ch
);
  import uqfe_pkg::*;

  logic      q_push, q_full, q_valid, q_pop;
  uqfe_pkt_t q_pkt_in, q_pkt_out;

  uqfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (!q_full),
    .q_push  (q_push),
    .q_pkt   (q_pkt_in)
  );

  uqfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_pkt_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_pkt_out)
  );

  uqfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pkt   (q_pkt_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `UQFE_ASSERT_NOW(a_push_not_full, q_push, !q_full, "packet pushed into full queue")
  `UQFE_ASSERT_NOW(a_pop_not_empty, q_pop, q_valid, "packet popped from empty queue")
  `UQFE_ASSERT_NEXT(a_push_pop_keeps, q_push && q_pop, q_valid, "queue lost a packet")

endmodule

FILE: rtl/core/uqfe_front.sv
// ----------------------------------------------------------------------------
// uqfe_front
// Tracks query phase and percent decoding; turns each byte into a packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uqfe_front (
  input  logic               clk,
  input  logic               rst_n,
  uqfe_in_if.sink            in_ch,
  input  logic               q_ready,
  output logic               q_push,
  output uqfe_pkg::uqfe_pkt_t q_pkt
);
  import uqfe_pkg::*;

  uqfe_phase_t phase_r, phase_nxt, ph_after;
  logic        pct_r, pct_nxt;
  logic        hv_r, hv_nxt;
  logic [7:0]  held_r, held_nxt;

  logic [7:0]                c;
  logic                      last;
  logic                      is_amp, is_eq;

  // feed result
  logic [1:0]                f_n;
  logic [MAX_TAKES-1:0][7:0] f_b;
  logic                      f_pct, f_hv;
  logic [7:0]                f_held;

  // flush of the current and of the post-feed decoder state
  logic [1:0]                cf_n, pf_n;
  logic [1:0][7:0]           cf_b, pf_b;
  logic [1:0]                j;

  function automatic logic is_hex(input logic [7:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
           (ch >= 8'h41 && ch <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] v;
    if (ch <= 8'h39) v = ch - 8'h30;
    else if (ch >= 8'h61) v = ch - 8'h57;
    else v = ch - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] plus_map(input logic [7:0] ch);
    return (ch == CH_PLUS) ? CH_SPACE : ch;
  endfunction

  assign c      = in_ch.url_byte;
  assign last   = in_ch.url_last;
  assign is_amp = (c == CH_AMP);
  assign is_eq  = (c == CH_EQ);

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  // percent decoder applied to the incoming byte
  always_comb begin
    f_n    = 2'd0;
    f_b    = '0;
    f_pct  = pct_r;
    f_hv   = hv_r;
    f_held = held_r;
    if (!pct_r) begin
      if (c == CH_PCT) begin
        f_pct = 1'b1;
      end else begin
        f_n    = 2'd1;
        f_b[0] = plus_map(c);
      end
    end else if (!hv_r) begin
      if (is_hex(c)) begin
        f_hv   = 1'b1;
        f_held = c;
      end else begin
        // failed escape: literal '%', then the byte starts afresh
        f_b[0] = CH_PCT;
        f_pct  = 1'b0;
        if (c == CH_PCT) begin
          f_pct = 1'b1;
          f_n   = 2'd1;
        end else begin
          f_n    = 2'd2;
          f_b[1] = plus_map(c);
        end
      end
    end else begin
      f_pct = 1'b0;
      f_hv  = 1'b0;
      if (is_hex(c)) begin
        f_n    = 2'd1;
        f_b[0] = {hex_val(held_r), hex_val(c)};
      end else begin
        f_b[0] = CH_PCT;
        f_b[1] = held_r;
        if (c == CH_PCT) begin
          f_pct = 1'b1;
          f_n   = 2'd2;
        end else begin
          f_n    = 2'd3;
          f_b[2] = plus_map(c);
        end
      end
    end
  end

  always_comb begin
    cf_n = pct_r ? (hv_r ? 2'd2 : 2'd1) : 2'd0;
    cf_b = {held_r, CH_PCT};
    pf_n = f_pct ? (f_hv ? 2'd2 : 2'd1) : 2'd0;
    pf_b = {f_held, CH_PCT};
  end

  // next state
  always_comb begin
    case (phase_r)
      PH_KEY:   ph_after = is_eq ? PH_VALUE : PH_KEY;
      PH_VALUE: ph_after = is_amp ? PH_KEY : PH_VALUE;
      default:  ph_after = (c == CH_QMARK) ? PH_KEY : PH_IDLE;
    endcase
    phase_nxt = last ? PH_IDLE : ph_after;

    pct_nxt  = pct_r;
    hv_nxt   = hv_r;
    held_nxt = held_r;
    if (last || (phase_r == PH_KEY && (is_amp || is_eq)) ||
        (phase_r == PH_VALUE && is_amp)) begin
      pct_nxt  = 1'b0;
      hv_nxt   = 1'b0;
      held_nxt = '0;
    end else if (phase_r == PH_KEY || phase_r == PH_VALUE) begin
      pct_nxt  = f_pct;
      hv_nxt   = f_hv;
      held_nxt = f_held;
    end
  end

  // packet
  always_comb begin
    q_pkt = '0;
    j     = 2'd0;
    case (phase_r)
      PH_KEY: begin
        q_pkt.key_ctx = 1'b1;
        if (is_amp) begin
          q_pkt.ev_key_end = 1'b1;
          q_pkt.ev_start   = 1'b1;
        end else if (is_eq) begin
          q_pkt.n_take         = cf_n;
          q_pkt.take_byte[1:0] = cf_b;
          q_pkt.ev_to_value    = 1'b1;
        end else begin
          q_pkt.n_take    = f_n;
          q_pkt.take_byte = f_b;
          q_pkt.upd_raw   = 1'b1;
          q_pkt.raw_clear = (c == CH_PCT) || (c == CH_PLUS);
        end
      end
      PH_VALUE: begin
        if (is_amp) begin
          q_pkt.n_take         = cf_n;
          q_pkt.take_byte[1:0] = cf_b;
          q_pkt.ev_val_end     = 1'b1;
          q_pkt.ev_start       = 1'b1;
        end else if (last) begin
          // end of URL inside a value: pending escape comes out literally
          q_pkt.n_take = 2'(f_n + pf_n);
          for (int i = 0; i < MAX_TAKES; i++) begin
            j = 2'(i) - f_n;
            if (2'(i) < f_n) q_pkt.take_byte[i] = f_b[i];
            else if (j < pf_n) q_pkt.take_byte[i] = j[0] ? pf_b[1] : pf_b[0];
          end
        end else begin
          q_pkt.n_take    = f_n;
          q_pkt.take_byte = f_b;
        end
      end
      default: begin
        q_pkt.ev_start = (c == CH_QMARK);
      end
    endcase
    if (last) begin
      q_pkt.ev_reset = 1'b1;
      if (ph_after == PH_KEY && !q_pkt.ev_start) q_pkt.ev_key_end = 1'b1;
      if (ph_after == PH_VALUE) q_pkt.ev_val_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pct_r   <= 1'b0;
      hv_r    <= 1'b0;
      held_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      pct_r   <= pct_nxt;
      hv_r    <= hv_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: rtl/core/uqfe_fifo.sv
// ----------------------------------------------------------------------------
// uqfe_fifo
// Small packet queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uqfe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  uqfe_pkg::uqfe_pkt_t din,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output uqfe_pkg::uqfe_pkt_t dout
);
  import uqfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uqfe_pkt_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/uqfe_back.sv
// ----------------------------------------------------------------------------
// uqfe_back
// Key matching, field routing and result emission through an output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uqfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  uqfe_pkg::uqfe_pkt_t q_pkt,
  output logic               q_pop,
  uqfe_out_if.source         out_ch
);
  import uqfe_pkg::*;

  logic [4:0]      kp_r, kp_nxt;
  logic [3:0]      dm_r, dm_nxt;
  logic [3:0]      raw_r, raw_nxt;
  logic [3:0]      seen_r, seen_nxt;
  logic            act_r, act_nxt;
  uqfe_field_t     fld_r, fld_nxt;

  logic            out_valid_r, out_valid_nxt;
  uqfe_res_t       out_r, out_nxt;
  uqfe_res_t       pend_r [MAX_RES-1];
  uqfe_res_t       pend_nxt [MAX_RES-1];
  logic [1:0]      pend_cnt_r, pend_cnt_nxt;

  uqfe_res_t       res [MAX_RES];
  logic [2:0]      res_cnt;
  logic [1:0]      m;
  logic            e_valid;
  uqfe_field_t     e_field;
  logic [2:0]      km, vm;
  logic            out_fire, consume;

  // per-step working copies
  logic [4:0]      kp_c;
  logic [3:0]      dm_c, raw_c, seen_c;
  logic            act_c;
  uqfe_field_t     fld_c;

  function automatic logic name_hit(input logic [1:0] n, input logic [4:0] pos,
                                    input logic [7:0] b);
    logic [4:0] idx;
    logic [7:0] ch;
    idx = NAME_LEN[n] - 5'd1 - pos;
    ch  = NAME_TXT[n][{idx, 3'b000} +: 8];
    return (pos < NAME_LEN[n]) && (ch == b);
  endfunction

  // {found, index}; lowest index wins
  function automatic logic [2:0] find_match(input logic [3:0] mask,
                                            input logic [4:0] pos);
    logic [2:0] r;
    r = '0;
    for (int n = NUM_NAMES - 1; n >= 0; n--) begin
      if (mask[n] && pos == NAME_LEN[n]) r = {1'b1, 2'(n)};
    end
    return r;
  endfunction

  assign out_fire = out_valid_r && out_ch.ready;
  assign consume  = q_valid && (pend_cnt_r == '0) && (!out_valid_r || out_fire);
  assign q_pop    = consume;

  // parser state and result list for the packet at the queue head
  always_comb begin
    kp_c    = kp_r;
    dm_c    = dm_r;
    raw_c   = raw_r;
    seen_c  = seen_r;
    act_c   = act_r;
    fld_c   = fld_r;
    e_valid = 1'b0;
    e_field = '0;
    km      = '0;
    vm      = '0;

    for (int i = 0; i < MAX_TAKES; i++) begin
      if (q_pkt.key_ctx && 2'(i) < q_pkt.n_take) begin
        for (int n = 0; n < NUM_NAMES; n++) begin
          if (!name_hit(2'(n), kp_c, q_pkt.take_byte[i])) dm_c[n] = 1'b0;
        end
        kp_c = (kp_c == KPOS_MAX) ? kp_c : kp_c + 5'd1;
      end
    end
    if (q_pkt.upd_raw) raw_c = (q_pkt.raw_clear ? 4'b0000 : raw_c) & dm_c;

    m = (!q_pkt.key_ctx && act_r) ? q_pkt.n_take : 2'd0;

    if (q_pkt.ev_key_end) begin
      // key without '=': raw key compare, empty value
      km = find_match(raw_c, kp_c);
      if (km[2] && !seen_c[km[1:0]]) begin
        seen_c[km[1:0]] = 1'b1;
        e_valid = 1'b1;
        e_field = km[1:0];
      end
    end
    if (q_pkt.ev_to_value) begin
      vm = find_match(dm_c, kp_c);
      if (vm[2] && !seen_c[vm[1:0]]) begin
        seen_c[vm[1:0]] = 1'b1;
        act_c = 1'b1;
        fld_c = vm[1:0];
      end
    end
    if (q_pkt.ev_val_end) begin
      if (act_c) begin
        e_valid = 1'b1;
        e_field = fld_c;
      end
      act_c = 1'b0;
    end
    if (q_pkt.ev_start || q_pkt.ev_reset) begin
      kp_c  = '0;
      dm_c  = '1;
      raw_c = '1;
      act_c = 1'b0;
      fld_c = '0;
    end
    if (q_pkt.ev_reset) seen_c = '0;

    res_cnt = {1'b0, m} + {2'b00, e_valid};
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;
    for (int i = 0; i < MAX_TAKES; i++) begin
      if (2'(i) < m) begin
        res[i].field    = fld_r;
        res[i].has_byte = 1'b1;
        res[i].data     = q_pkt.take_byte[i];
      end
    end
    if (e_valid) begin
      res[m].field     = e_field;
      res[m].value_end = 1'b1;
      res[m].run_last  = 1'b1;
    end else if (m != 2'd0) begin
      res[m - 2'd1].run_last = 1'b1;
    end

    kp_nxt   = consume ? kp_c   : kp_r;
    dm_nxt   = consume ? dm_c   : dm_r;
    raw_nxt  = consume ? raw_c  : raw_r;
    seen_nxt = consume ? seen_c : seen_r;
    act_nxt  = consume ? act_c  : act_r;
    fld_nxt  = consume ? fld_c  : fld_r;
  end

  // output register with a short shift of pending results
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (consume) begin
      out_valid_nxt = (res_cnt != 3'd0);
      out_nxt       = res[0];
      for (int i = 0; i < MAX_RES - 1; i++) pend_nxt[i] = res[i + 1];
      pend_cnt_nxt  = (res_cnt == 3'd0) ? 2'd0 : 2'(res_cnt - 3'd1);
    end else if (pend_cnt_r != 2'd0 && (!out_valid_r || out_fire)) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r[0];
      for (int i = 0; i < MAX_RES - 2; i++) pend_nxt[i] = pend_r[i + 1];
      pend_cnt_nxt  = pend_cnt_r - 2'd1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      dm_r        <= '1;
      raw_r       <= '1;
      seen_r      <= '0;
      act_r       <= 1'b0;
      fld_r       <= '0;
      out_valid_r <= 1'b0;
      pend_cnt_r  <= '0;
    end else begin
      kp_r        <= kp_nxt;
      dm_r        <= dm_nxt;
      raw_r       <= raw_nxt;
      seen_r      <= seen_nxt;
      act_r       <= act_nxt;
      fld_r       <= fld_nxt;
      out_valid_r <= out_valid_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.field     = out_r.field;
  assign out_ch.has_byte  = out_r.has_byte;
  assign out_ch.data      = out_r.data;
  assign out_ch.value_end = out_r.value_end;
  assign out_ch.run_last  = out_r.run_last;

endmodule

FILE: verif/url_query_field_extractor_tb.sv
// ----------------------------------------------------------------------------
// url_query_field_extractor_tb
// Drives URLs byte by byte through the extractor and checks every field
// result against an in-bench parser of the query, under random idling on
// both channels, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module url_query_field_extractor_tb;
  import uqfe_pkg::*;

  // Query parser plus the store of field results still owed by the DUT.
  class field_scoreboard;
    uqfe_res_t   field_results_due[$];
    uqfe_res_t   step_results[$];
    int unsigned mismatches;
    string       names[NUM_NAMES];

    uqfe_phase_t phase;
    bit          pct_pending;
    bit          held_valid;
    bit [7:0]    held_char;
    bit [4:0]    key_pos;
    bit [3:0]    dec_match;
    bit [3:0]    raw_match;
    bit [3:0]    seen;
    bit          routing;
    bit [1:0]    route_fld;

    function new();
      names[0] = "code";
      names[1] = "state";
      names[2] = "error";
      names[3] = "error";
      names[3] = {names[3], "_description"};
      mismatches = 0;
      restart_url();
    endfunction

    function void clear_escape();
      pct_pending = 1'b0;
      held_valid  = 1'b0;
      held_char   = 8'h00;
    endfunction

    function void restart_url();
      phase = PH_IDLE;
      clear_escape();
      key_pos   = '0;
      dec_match = 4'hF;
      raw_match = 4'hF;
      seen      = '0;
      routing   = 1'b0;
      route_fld = '0;
    endfunction

    function void push_result(bit [1:0] fld, bit has, bit [7:0] dat, bit fin);
      uqfe_res_t r;
      r.field     = fld;
      r.has_byte  = has;
      r.data      = dat;
      r.value_end = fin;
      r.run_last  = 1'b0;
      if (step_results.size() < MAX_RES) step_results.insert(step_results.size(), r);
    endfunction

    function int hex_digit(bit [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return 10 + (c - 8'h61);
      if (c >= 8'h41 && c <= 8'h46) return 10 + (c - 8'h41);
      return -1;
    endfunction

    // One decoded byte: narrows the key match, or goes out as value data.
    function void consume(bit [7:0] b);
      if (phase == PH_KEY) begin
        for (int n = 0; n < NUM_NAMES; n++) begin
          if (key_pos >= names[n].len() || 8'(names[n][key_pos]) != b) dec_match[n] = 1'b0;
        end
        key_pos = (key_pos < KPOS_MAX) ? key_pos + 5'd1 : KPOS_MAX;
      end else if (phase == PH_VALUE && routing) begin
        push_result(route_fld, 1'b1, b, 1'b0);
      end
    endfunction

    function void decode_plain(bit [7:0] c);
      if (c == CH_PCT) pct_pending = 1'b1;
      else if (c == CH_PLUS) consume(CH_SPACE);
      else consume(c);
    endfunction

    function void decode(bit [7:0] c);
      int       lo;
      bit [7:0] held;
      if (!pct_pending) begin
        decode_plain(c);
      end else if (!held_valid) begin
        if (hex_digit(c) >= 0) begin
          held_valid = 1'b1;
          held_char  = c;
        end else begin
          clear_escape();
          consume(CH_PCT);
          decode_plain(c);
        end
      end else begin
        lo   = hex_digit(c);
        held = held_char;
        clear_escape();
        if (lo >= 0) begin
          consume(8'((hex_digit(held) << 4) | lo));
        end else begin
          // failed escape: literal '%' and digit, offending byte starts over
          consume(CH_PCT);
          consume(held);
          decode_plain(c);
        end
      end
    endfunction

    function void flush_escape();
      bit [7:0] held;
      bit       hv;
      if (pct_pending) begin
        held = held_char;
        hv   = held_valid;
        clear_escape();
        consume(CH_PCT);
        if (hv) consume(held);
      end
    endfunction

    function int find_name(bit [3:0] mask);
      for (int n = 0; n < NUM_NAMES; n++) begin
        if (mask[n] && key_pos == names[n].len()) return n;
      end
      return -1;
    endfunction

    function void start_item();
      phase = PH_KEY;
      clear_escape();
      key_pos   = '0;
      dec_match = 4'hF;
      raw_match = 4'hF;
      routing   = 1'b0;
      route_fld = '0;
    endfunction

    // Item without '=': raw key compare, empty value.
    function void close_bare_key();
      int n;
      flush_escape();
      n = find_name(raw_match);
      if (n >= 0 && !seen[n]) begin
        seen[n] = 1'b1;
        push_result(2'(n), 1'b0, 8'h00, 1'b1);
      end
    endfunction

    function void open_value();
      int n;
      flush_escape();
      n = find_name(dec_match);
      phase = PH_VALUE;
      clear_escape();
      if (n >= 0 && !seen[n]) begin
        seen[n]   = 1'b1;
        routing   = 1'b1;
        route_fld = 2'(n);
      end
    endfunction

    function void close_value();
      flush_escape();
      if (routing) push_result(route_fld, 1'b0, 8'h00, 1'b1);
      routing = 1'b0;
    endfunction

    function void note_url_byte(bit [7:0] c, bit last);
      step_results.delete();
      case (phase)
        PH_KEY: begin
          if (c == CH_AMP) begin
            close_bare_key();
            start_item();
          end else if (c == CH_EQ) begin
            open_value();
          end else begin
            if (c == CH_PCT || c == CH_PLUS) raw_match = '0;
            decode(c);
            raw_match &= dec_match;
          end
        end
        PH_VALUE: begin
          if (c == CH_AMP) begin
            close_value();
            start_item();
          end else begin
            decode(c);
          end
        end
        default: begin
          if (c == CH_QMARK) start_item();
        end
      endcase
      if (last) begin
        if (phase == PH_KEY) close_bare_key();
        else if (phase == PH_VALUE) close_value();
        restart_url();
      end
      foreach (step_results[k]) begin
        step_results[k].run_last = (k == step_results.size() - 1);
        field_results_due.insert(field_results_due.size(), step_results[k]);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_field_result(uqfe_res_t got);
      uqfe_res_t want;
      if (field_results_due.size() == 0) begin
        flag($sformatf("unexpected result: field %0d has_byte %0b data %02h end %0b last %0b",
                       got.field, got.has_byte, got.data, got.value_end, got.run_last));
        return;
      end
      want = field_results_due.pop_front();
      if (got.field !== want.field || got.has_byte !== want.has_byte ||
          got.data !== want.data || got.value_end !== want.value_end ||
          got.run_last !== want.run_last) begin
        flag($sformatf({"mismatch: exp field %0d has %0b data %02h end %0b last %0b, ",
                        "got field %0d has %0b data %02h end %0b last %0b"},
                       want.field, want.has_byte, want.data, want.value_end, want.run_last,
                       got.field, got.has_byte, got.data, got.value_end, got.run_last));
      end
    endfunction

    function void flag_leftovers();
      if (field_results_due.size() != 0)
        flag($sformatf("%0d field results never arrived", field_results_due.size()));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  uqfe_in_if  in_ch ();
  uqfe_out_if out_ch ();

  url_query_field_extractor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  field_scoreboard board;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_request;
  int              bytes_sent;
  bit [7:0]        url_buf[$];

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Called right after a falling edge; returns right after one.
  task automatic send_byte(input bit [7:0] b, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.url_byte = b;
    in_ch.url_last = last;
    forever begin
      @(posedge clk);
      if (in_ch.ready === 1'b1) break;
    end
    board.note_url_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_url();
    for (int i = 0; i < url_buf.size(); i++) send_byte(url_buf[i], i == url_buf.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (board.field_results_due.size() != 0) @(negedge clk);
  endtask

  function automatic void add_byte(input bit [7:0] b);
    url_buf.insert(url_buf.size(), b);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic bit [7:0] hex_char(bit [3:0] v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic bit [7:0] non_hex();
    return 8'($urandom_range(8'h67, 8'h7A));
  endfunction

  function automatic bit [7:0] any_but_amp();
    bit [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_AMP) ? 8'h61 : b;
  endfunction

  function automatic bit [7:0] key_noise();
    bit [7:0] b;
    case ($urandom_range(0, 5))
      0: b = CH_PLUS;
      1: b = CH_PCT;
      2, 3: b = 8'($urandom_range(8'h61, 8'h7A));
      default: b = any_but_amp();
    endcase
    return (b == CH_EQ) ? 8'h5F : b;
  endfunction

  task automatic gen_key();
    int       sel;
    int       k;
    string    nm;
    bit [7:0] ch;
    sel = $urandom_range(0, 19);
    nm  = board.names[$urandom_range(0, NUM_NAMES - 1)];
    if (sel < 11) begin
      push_text(nm);
    end else if (sel < 14) begin
      // one character of the name percent-encoded
      k = $urandom_range(0, nm.len() - 1);
      for (int i = 0; i < nm.len(); i++) begin
        ch = nm[i];
        if (i == k) begin
          add_byte(CH_PCT);
          add_byte(hex_char(ch[7:4]));
          add_byte(hex_char(ch[3:0]));
        end else begin
          add_byte(ch);
        end
      end
    end else if (sel < 16) begin
      if ($urandom_range(0, 1) == 0) begin
        push_text(nm.substr(0, nm.len() - 2));
      end else begin
        push_text(nm);
        add_byte(8'h73);
      end
    end else if (sel < 19) begin
      repeat ($urandom_range(0, 4)) add_byte(key_noise());
    end else begin
      // long key, at times long enough to saturate the key position
      repeat ($urandom_range(28, 36)) add_byte(8'h78);
    end
  endtask

  task automatic gen_value(input int len);
    repeat (len) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          add_byte(CH_PCT);
          add_byte(hex_char(4'($urandom_range(0, 15))));
          add_byte(hex_char(4'($urandom_range(0, 15))));
        end
        2: begin
          add_byte(CH_PCT);
          add_byte(hex_char(4'($urandom_range(0, 15))));
          add_byte(($urandom_range(0, 2) == 0) ? CH_PCT : non_hex());
        end
        3: begin
          add_byte(CH_PCT);
          add_byte(non_hex());
        end
        4: add_byte(CH_PLUS);
        5: add_byte(CH_EQ);
        6: add_byte(CH_QMARK);
        7: add_byte(CH_PCT);
        default: add_byte(any_but_amp());
      endcase
    end
  endtask

  task automatic gen_url();
    bit [7:0] b;
    int       items;
    url_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes, may or may not hold a query
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        b = 8'($urandom_range(0, 255));
        add_byte((b == CH_QMARK) ? 8'h68 : b);
      end
      add_byte(CH_QMARK);
      items = $urandom_range(1, 4);
      for (int i = 0; i < items; i++) begin
        if (i > 0) add_byte(CH_AMP);
        gen_key();
        if ($urandom_range(0, 4) != 0) begin
          add_byte(CH_EQ);
          gen_value($urandom_range(0, 5));
        end
      end
      if ($urandom_range(0, 7) == 0) add_byte(CH_AMP);
    end
  endtask

  // Result sink: random ready, plus a long hold-off on request.
  initial begin
    uqfe_res_t got;
    int        hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 90;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.field     = out_ch.field;
        got.has_byte  = out_ch.has_byte;
        got.data      = out_ch.data;
        got.value_end = out_ch.value_end;
        got.run_last  = out_ch.run_last;
        board.check_field_result(got);
      end
    end
  end

  initial begin
    int goal;
    in_ch.valid    = 1'b0;
    in_ch.url_byte = 8'h00;
    in_ch.url_last = 1'b0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_request   = 1'b0;
    bytes_sent     = 0;
    board          = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // failed escape without digit, '+', extra '?', repeated name
    url_buf.delete();
    push_text("?code=%z+?&code");
    send_url();
    // failed escape with held digit, extra '=', unfinished escape, bare key
    url_buf.delete();
    push_text("?error=%4=%&state");
    send_url();
    // no query at all, byte extremes
    url_buf.delete();
    add_byte(8'hFF);
    add_byte(8'h00);
    send_url();
    wait_drained();

    goal = bytes_sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 36; recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 2) begin
        // output held off while a value-heavy URL keeps coming
        hold_request = 1'b1;
        url_buf.delete();
        push_text("?code=");
        gen_value(12);
        push_text("&state=");
        gen_value(8);
        send_url();
      end
      goal += 64;
      while (bytes_sent < goal) begin
        gen_url();
        send_url();
      end
      wait_drained();
    end

    repeat (16) @(negedge clk);
    board.flag_leftovers();
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
